@@ sv/cct_pkg.sv @@
// ----------------------------------------------------------------------------
// cct_pkg
// Shared types and constants of the configurable character tokenizer: scan
// modes, event kinds, configuration register indexes and the event list.
// ----------------------------------------------------------------------------
package cct_pkg;

    // Slots examined in each character list (eight bytes per 64-bit register)
    localparam int unsigned SET_SLOTS = 8;
    // Largest number of result items one input item can cause
    localparam int unsigned EV_MAX    = 4;

    // Input command carried on tuser
    localparam logic CMD_BYTE = 1'b0;
    localparam logic CMD_END  = 1'b1;

    // Configuration register indexes
    localparam logic [2:0] REG_BREAK_SET   = 3'd0;
    localparam logic [2:0] REG_WHITE_SET   = 3'd1;
    localparam logic [2:0] REG_QUOTE_SET   = 3'd2;
    localparam logic [2:0] REG_ESCAPE_BYTE = 3'd3;
    localparam logic [2:0] REG_CASE_MODE   = 3'd4;
    localparam logic [2:0] REG_SKIP_LINE   = 3'd5;
    localparam logic [2:0] REG_SKIP_BLOCK  = 3'd6;

    // Case folding modes
    localparam logic [1:0] CASE_KEEP  = 2'd0;
    localparam logic [1:0] CASE_UPPER = 2'd1;
    localparam logic [1:0] CASE_LOWER = 2'd2;

    // Reset values of the configuration registers
    localparam logic [63:0] BREAK_SET_RST = 64'h0000_0000_0A3B_3D2C; // , ; = \n
    localparam logic [63:0] WHITE_SET_RST = 64'h0000_0000_000D_0920; // space \t \r
    localparam logic [63:0] QUOTE_SET_RST = 64'h0000_0000_0000_2227; // ' "

    // Characters with a fixed meaning
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_NL    = 8'h0A;

    typedef enum logic [2:0] {
        M_WHITE = 3'd0,
        M_WORD  = 3'd1,
        M_QUOTE = 3'd2,
        M_LINE  = 3'd3,
        M_BLOCK = 3'd4
    } scan_mode_t;

    typedef enum logic [2:0] {
        EV_CHAR   = 3'd0,
        EV_WORD   = 3'd1,
        EV_STRING = 3'd2,
        EV_BREAK  = 3'd3,
        EV_END    = 3'd4
    } ev_kind_t;

    typedef struct packed {
        logic [63:0] break_set;
        logic [63:0] white_set;
        logic [63:0] quote_set;
        logic [7:0]  escape_byte;
        logic [1:0]  case_mode;
        logic        skip_line;
        logic        skip_block;
    } cfg_t;

    typedef struct packed {
        scan_mode_t  mode;
        logic [7:0]  open_quote;
        logic        slash_pend;
        logic        esc_pend;
        logic        star_seen;
    } scan_state_t;

    typedef struct packed {
        ev_kind_t    kind;
        logic [7:0]  data;
    } ev_t;

    typedef struct packed {
        logic [2:0]           cnt;
        ev_t [EV_MAX-1:0]     ev;
    } ev_list_t;

    // Status from the result buffer to the input side
    typedef struct packed {
        logic free;     // buffer empty, or emptying in this cycle
        logic busy;     // results still waiting
    } buf_stat_t;

    localparam scan_state_t SCAN_RST = '{
        mode:       M_WHITE,
        open_quote: 8'h00,
        slash_pend: 1'b0,
        esc_pend:   1'b0,
        star_seen:  1'b0
    };

endpackage

@@ sv/configurable_char_tokenizer_core.sv @@
// ----------------------------------------------------------------------------
// configurable_char_tokenizer_core
// Byte-stream tokenizer with configurable break, white and quote lists, an
// escape byte, optional comment skipping and ASCII case folding of words.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Payload                                 Accept on
//  --------  ---------  --------------------------------------  --------------------
//  s_        in         tdata[7:0] text_byte, tuser cmd          s_tvalid & s_tready
//  m_        out        tdata[2:0] kind, [10:3] byte, tlast      m_tvalid & m_tready
//  cfg_      in         cfg_addr register index, cfg_wdata       cfg_wr_en
//
//  An accepted item lands in the input register; once the buffer is free the step
//  logic classes it and loads its events (none to four) into the result buffer.
//  One item per cycle while each item gives at most one result and m_tready is
//  high; an item giving more holds the input side until its last result is taken.
//  A stall on m_tready holds the buffer and, once the input register is full,
//  drops s_tready. Reset is synchronous and returns scan state and registers to
//  their defaults; no clearing pass is needed.
//
module configurable_char_tokenizer_core (
    input  logic        aclk,
    input  logic        aresetn,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] text_byte
    input  logic        s_tuser,    // [0] cmd
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,    // [2:0] event_kind, [10:3] event_byte, rest zero
    output logic        m_tlast,    // last_of_run
    // configuration
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_addr,
    input  logic [63:0] cfg_wdata
);
    import cct_pkg::*;

    // Configuration registers
    cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.break_set   <= BREAK_SET_RST;
            cfg_reg.white_set   <= WHITE_SET_RST;
            cfg_reg.quote_set   <= QUOTE_SET_RST;
            cfg_reg.escape_byte <= 8'h00;
            cfg_reg.case_mode   <= CASE_KEEP;
            cfg_reg.skip_line   <= 1'b0;
            cfg_reg.skip_block  <= 1'b0;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                REG_BREAK_SET:   cfg_reg.break_set   <= cfg_wdata;
                REG_WHITE_SET:   cfg_reg.white_set   <= cfg_wdata;
                REG_QUOTE_SET:   cfg_reg.quote_set   <= cfg_wdata;
                REG_ESCAPE_BYTE: cfg_reg.escape_byte <= cfg_wdata[7:0];
                REG_CASE_MODE:   cfg_reg.case_mode   <= cfg_wdata[1:0];
                REG_SKIP_LINE:   cfg_reg.skip_line   <= cfg_wdata[0];
                REG_SKIP_BLOCK:  cfg_reg.skip_block  <= cfg_wdata[0];
                default: ;       // index beyond the list: drop the write
            endcase
        end
    end

    // Input register
    logic       in_valid_reg, in_valid_next;
    logic       in_cmd_reg;
    logic [7:0] in_byte_reg;
    logic       s_fire;
    logic       proc_fire;
    buf_stat_t  buf_stat;

    // Advance the input register whenever the buffer can take its events
    assign proc_fire = in_valid_reg && buf_stat.free;
    assign s_tready  = !in_valid_reg || proc_fire;
    assign s_fire    = s_tvalid && s_tready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_fire) begin
            in_valid_next = 1'b1;
        end else if (proc_fire) begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_cmd_reg  <= s_tuser;
            in_byte_reg <= s_tdata;
        end
    end

    // Scan state, updated once per processed item
    scan_state_t scan_reg, scan_next;
    ev_list_t    step_events;

    cct_step u_step (
        .cfg       (cfg_reg),
        .state_in  (scan_reg),
        .cmd       (in_cmd_reg),
        .text_byte (in_byte_reg),
        .state_out (scan_next),
        .events    (step_events)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scan_reg <= SCAN_RST;
        end else if (proc_fire) begin
            scan_reg <= scan_next;
        end
    end

    // Result buffer and output side
    cct_burst u_burst (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (proc_fire),
        .events   (step_events),
        .stat     (buf_stat),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // An open quote byte is held exactly while inside a string
    a_quote_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (scan_reg.mode == M_QUOTE) == (scan_reg.open_quote != 8'h00))
        else $error("open quote byte out of step with quote mode");

    // A slash and an escape are never held together
    a_one_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        !(scan_reg.slash_pend && scan_reg.esc_pend))
        else $error("slash and escape both pending");

    // End of text returns the scan state to reset
    a_end_resets: assert property (@(posedge aclk) disable iff (!aresetn)
        (proc_fire && in_cmd_reg == CMD_END) |=> (scan_reg == SCAN_RST))
        else $error("scan state not cleared after end of text");

    // The buffer is never reloaded while results still wait unaccepted
    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        (buf_stat.busy && !m_tready) |-> !proc_fire)
        else $error("result buffer reloaded during a stall");

    // A star seen is only tracked inside a block comment
    a_star_scope: assert property (@(posedge aclk) disable iff (!aresetn)
        scan_reg.star_seen |-> (scan_reg.mode == M_BLOCK))
        else $error("star flag set outside a block comment");

endmodule

@@ sv/cct_step.sv @@
// ----------------------------------------------------------------------------
// cct_step
// Combinational tokenizer step: classes one byte (or end of text) against the
// configured lists and gives the next scan state and the events of the item.
// ----------------------------------------------------------------------------
module cct_step (
    input  cct_pkg::cfg_t        cfg,
    input  cct_pkg::scan_state_t state_in,
    input  logic                 cmd,
    input  logic [7:0]           text_byte,
    output cct_pkg::scan_state_t state_out,
    output cct_pkg::ev_list_t    events
);
    import cct_pkg::*;

    localparam logic [7:0] CH_LC_A = 8'h61;
    localparam logic [7:0] CH_LC_Z = 8'h7A;
    localparam logic [7:0] CH_UC_A = 8'h41;
    localparam logic [7:0] CH_UC_Z = 8'h5A;
    localparam logic [7:0] CASE_BIT = 8'h20;

    typedef struct packed {
        scan_state_t st;
        ev_list_t    evs;
    } work_t;

    // List membership: a zero byte ends the list and is never a member
    function automatic logic in_set(logic [63:0] set, logic [7:0] b);
        logic found;
        logic stop;
        logic [7:0] s;
        found = 1'b0;
        stop  = 1'b0;
        for (int i = 0; i < SET_SLOTS; i++) begin
            s = set[8*i +: 8];
            if (!stop) begin
                if (s == 8'h00) begin
                    stop = 1'b1;
                end else if (s == b) begin
                    found = 1'b1;
                    stop  = 1'b1;
                end
            end
        end
        return found;
    endfunction

    function automatic work_t push_ev(work_t w, ev_kind_t k, logic [7:0] b);
        work_t r;
        r = w;
        if (r.evs.cnt < 3'(EV_MAX)) begin
            r.evs.ev[r.evs.cnt[1:0]].kind = k;
            r.evs.ev[r.evs.cnt[1:0]].data = b;
            r.evs.cnt = r.evs.cnt + 3'd1;
        end
        return r;
    endfunction

    // Fold word characters only; quoted text stays as is
    function automatic work_t emit_char(work_t w, cfg_t c, logic [7:0] b);
        logic [7:0] f;
        f = b;
        if (w.st.mode == M_WORD) begin
            if (c.case_mode == CASE_UPPER && b >= CH_LC_A && b <= CH_LC_Z) begin
                f = b ^ CASE_BIT;
            end else if (c.case_mode == CASE_LOWER && b >= CH_UC_A && b <= CH_UC_Z) begin
                f = b ^ CASE_BIT;
            end
        end
        return push_ev(w, EV_CHAR, f);
    endfunction

    function automatic work_t classify(work_t w, cfg_t c, logic [7:0] b);
        work_t r;
        r = w;
        if (in_set(c.break_set, b)) begin
            if (r.st.mode == M_QUOTE) begin
                r = emit_char(r, c, b);
            end else begin
                if (r.st.mode == M_WORD) begin
                    r = push_ev(r, EV_WORD, 8'h00);
                end
                r.st.mode = M_WHITE;
                r = push_ev(r, EV_BREAK, b);
            end
        end else if (in_set(c.quote_set, b)) begin
            if (r.st.mode == M_QUOTE) begin
                if (b == r.st.open_quote) begin
                    r = push_ev(r, EV_STRING, b);
                    r.st.mode       = M_WHITE;
                    r.st.open_quote = 8'h00;
                end else begin
                    r = emit_char(r, c, b);
                end
            end else begin
                if (r.st.mode == M_WORD) begin
                    r = push_ev(r, EV_WORD, 8'h00);
                end
                r.st.mode       = M_QUOTE;
                r.st.open_quote = b;
            end
        end else if (in_set(c.white_set, b)) begin
            if (r.st.mode == M_QUOTE) begin
                r = emit_char(r, c, b);
            end else if (r.st.mode == M_WORD) begin
                r = push_ev(r, EV_WORD, 8'h00);
                r.st.mode = M_WHITE;
            end
        end else if (c.escape_byte != 8'h00 && b == c.escape_byte) begin
            if (r.st.mode == M_WHITE) begin
                r.st.mode = M_WORD;
            end
            r.st.esc_pend = 1'b1;
        end else begin
            if (r.st.mode == M_WHITE) begin
                r.st.mode = M_WORD;
            end
            r = emit_char(r, c, b);
        end
        return r;
    endfunction

    // Hold a slash outside quotes while comment skipping is on
    function automatic work_t handle_byte(work_t w, cfg_t c, logic [7:0] b);
        work_t r;
        r = w;
        if (r.st.mode != M_QUOTE && b == CH_SLASH && (c.skip_line || c.skip_block)) begin
            r.st.slash_pend = 1'b1;
        end else begin
            r = classify(r, c, b);
        end
        return r;
    endfunction

    function automatic work_t start_comment(work_t w, scan_mode_t m);
        work_t r;
        r = w;
        if (r.st.mode == M_WORD) begin
            r = push_ev(r, EV_WORD, 8'h00);
        end
        r.st.mode      = m;
        r.st.star_seen = 1'b0;
        return r;
    endfunction

    work_t w;

    always_comb begin
        w.st  = state_in;
        w.evs = '0;
        if (cmd == CMD_END) begin
            // Flush a held slash or escape, close any token, then reset
            if (w.st.slash_pend) begin
                w.st.slash_pend = 1'b0;
                w = classify(w, cfg, CH_SLASH);
            end else if (w.st.esc_pend) begin
                w.st.esc_pend = 1'b0;
                w = emit_char(w, cfg, cfg.escape_byte);
            end
            if (w.st.mode == M_WORD || w.st.mode == M_QUOTE) begin
                w = push_ev(w, EV_WORD, 8'h00);
            end
            w = push_ev(w, EV_END, 8'h00);
            w.st = SCAN_RST;
        end else if (w.st.mode == M_LINE) begin
            if (text_byte == CH_NL) begin
                w.st.mode = M_WHITE;
            end
        end else if (w.st.mode == M_BLOCK) begin
            if (w.st.star_seen && text_byte == CH_SLASH) begin
                w.st.mode      = M_WHITE;
                w.st.star_seen = 1'b0;
            end else begin
                w.st.star_seen = (text_byte == CH_STAR);
            end
        end else if (w.st.esc_pend) begin
            w.st.esc_pend = 1'b0;
            w = emit_char(w, cfg, text_byte);
        end else if (w.st.slash_pend) begin
            w.st.slash_pend = 1'b0;
            if (text_byte == CH_SLASH && cfg.skip_line) begin
                w = start_comment(w, M_LINE);
            end else if (text_byte == CH_STAR && cfg.skip_block) begin
                w = start_comment(w, M_BLOCK);
            end else begin
                w = classify(w, cfg, CH_SLASH);
                if (w.st.esc_pend) begin
                    w.st.esc_pend = 1'b0;
                    w = emit_char(w, cfg, text_byte);
                end else begin
                    w = handle_byte(w, cfg, text_byte);
                end
            end
        end else begin
            w = handle_byte(w, cfg, text_byte);
        end
    end

    assign state_out = w.st;
    assign events    = w.evs;

endmodule

@@ sv/cct_burst.sv @@
// ----------------------------------------------------------------------------
// cct_burst
// Result buffer: holds the events of one input item and hands them out one
// per cycle on the master side while m_tready is high, marking the last one with tlast.
// ----------------------------------------------------------------------------
module cct_burst (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                load,
    input  cct_pkg::ev_list_t   events,
    output cct_pkg::buf_stat_t  stat,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [15:0]         m_tdata,   // [2:0] event_kind, [10:3] event_byte
    output logic                m_tlast
);
    import cct_pkg::*;

    ev_t [EV_MAX-1:0] ev_reg;
    logic [2:0]       rem_reg, rem_next;
    logic [1:0]       head_reg, head_next;
    logic             pop;

    assign pop = m_tvalid && m_tready;

    always_comb begin
        rem_next  = rem_reg;
        head_next = head_reg;
        if (load) begin
            rem_next  = events.cnt;
            head_next = 2'd0;
        end else if (pop) begin
            rem_next  = rem_reg - 3'd1;
            head_next = head_reg + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rem_reg  <= 3'd0;
            head_reg <= 2'd0;
        end else begin
            rem_reg  <= rem_next;
            head_reg <= head_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            ev_reg <= events.ev;
        end
    end

    assign m_tvalid  = (rem_reg != 3'd0);
    assign m_tlast   = (rem_reg == 3'd1);
    assign m_tdata   = {5'd0, ev_reg[head_reg].data, ev_reg[head_reg].kind};
    assign stat.free = (rem_reg == 3'd0) || (rem_reg == 3'd1 && m_tready);
    assign stat.busy = m_tvalid;

endmodule
